@@ rtl/core/fast_inverse_square_root_macros.svh @@
// ---------------------------------------------------------------------------
// fast_inverse_square_root_macros
// assertion shorthands shared by the inverse square root pipeline
// ---------------------------------------------------------------------------
`ifndef FAST_INVERSE_SQUARE_ROOT_MACROS_SVH
`define FAST_INVERSE_SQUARE_ROOT_MACROS_SVH

// same-cycle implication, checked out of reset
`define FISR_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fisr check failed");

// next-cycle implication, checked out of reset
`define FISR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fisr check failed");

`endif

@@ rtl/core/fisr_pkg.sv @@
// ---------------------------------------------------------------------------
// fisr_pkg
// shared types and single-precision arithmetic for the inverse square root
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fisr_pkg;

    localparam logic [31:0] SEED_MAGIC = 32'h5f375a86;
    localparam logic [31:0] QNAN       = 32'h7fc00000;
    localparam logic [31:0] HALF       = 32'h3f000000;
    localparam logic [31:0] THREE_HALF = 32'h3fc00000;

    // operands into a multiply stage, seed rides along
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] seed;
    } mul_ops_t;

    // value leaving a stage, seed rides along
    typedef struct packed {
        logic [31:0] val;
        logic [31:0] seed;
    } pipe_t;

    // single-precision multiply, round to nearest even, gradual underflow
    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic               sgn;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [7:0]         eav;
        logic [7:0]         ebv;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [47:0]        p;
        logic [5:0]         lz;
        logic               found;
        logic signed [10:0] er;
        logic signed [10:0] shs;
        logic [5:0]         sh;
        logic [95:0]        ext;
        logic [47:0]        kept;
        logic               stk;
        logic               inc;
        logic [7:0]         field;
        logic [31:0]        body;
        logic               a_nan;
        logic               b_nan;
        logic               a_inf;
        logic               b_inf;
        logic               a_zero;
        logic               b_zero;
        sgn    = a[31] ^ b[31];
        ea     = a[30:23];
        eb     = b[30:23];
        a_nan  = (ea == 8'hff) && (a[22:0] != 23'd0);
        b_nan  = (eb == 8'hff) && (b[22:0] != 23'd0);
        a_inf  = (ea == 8'hff) && (a[22:0] == 23'd0);
        b_inf  = (eb == 8'hff) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
        begin
            return QNAN;
        end
        if (a_inf || b_inf)
        begin
            return {sgn, 8'hff, 23'd0};
        end
        if (a_zero || b_zero)
        begin
            return {sgn, 31'd0};
        end
        ma  = {(ea != 8'd0), a[22:0]};
        mb  = {(eb != 8'd0), b[22:0]};
        eav = (ea == 8'd0) ? 8'd1 : ea;
        ebv = (eb == 8'd0) ? 8'd1 : eb;
        p   = ma * mb;
        // leading zero count of the product
        lz    = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && p[i])
            begin
                lz    = 6'(47 - i);
                found = 1'b1;
            end
        end
        p  = p << lz;
        er = $signed({3'b000, eav}) + $signed({3'b000, ebv}) - 11'sd126
             - $signed({5'b00000, lz});
        if (er >= 11'sd255)
        begin
            return {sgn, 8'hff, 23'd0};
        end
        if (er <= 11'sd0)
        begin
            // subnormal result, shift right with sticky
            shs   = 11'sd1 - er;
            sh    = (shs > 11'sd48) ? 6'd48 : shs[5:0];
            ext   = {p, 48'd0} >> sh;
            kept  = ext[95:48];
            stk   = |ext[47:0];
            field = 8'd0;
        end
        else
        begin
            kept  = p;
            stk   = 1'b0;
            field = er[7:0];
        end
        stk  = stk | (|kept[22:0]);
        inc  = kept[23] & (stk | kept[24]);
        body = {1'b0, field, kept[46:24]} + {31'd0, inc};
        return {sgn, body[30:0]};
    endfunction

    // single-precision add, round to nearest even, gradual underflow
    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] sml;
        logic        sgn;
        logic        sub;
        logic [7:0]  eb;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [4:0]  dc;
        logic [26:0] am;
        logic [26:0] bx;
        logic [53:0] ext;
        logic [26:0] bm;
        logic [27:0] s;
        logic [26:0] n;
        logic [8:0]  e;
        logic [4:0]  lz;
        logic        found;
        logic [8:0]  lim;
        logic [8:0]  sh;
        logic [7:0]  field;
        logic        inc;
        logic [31:0] body;
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
        begin
            return QNAN;
        end
        if (a_inf)
        begin
            return a;
        end
        if (b_inf)
        begin
            return b;
        end
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
        begin
            return {a[31] & b[31], 31'd0};
        end
        if (a[30:0] == 31'd0)
        begin
            return b;
        end
        if (b[30:0] == 31'd0)
        begin
            return a;
        end
        // larger magnitude first
        if (b[30:0] > a[30:0])
        begin
            big = b;
            sml = a;
        end
        else
        begin
            big = a;
            sml = b;
        end
        sgn = big[31];
        sub = a[31] ^ b[31];
        eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d   = eb - es;
        dc  = (d > 8'd27) ? 5'd27 : d[4:0];
        am  = {(big[30:23] != 8'd0), big[22:0], 3'b000};
        bx  = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
        // align smaller operand with sticky
        ext = {bx, 27'd0} >> dc;
        bm  = ext[53:27] | {26'd0, |ext[26:0]};
        s   = sub ? ({1'b0, am} - {1'b0, bm}) : ({1'b0, am} + {1'b0, bm});
        if (s == 28'd0)
        begin
            return 32'd0;
        end
        e = {1'b0, eb};
        if (s[27])
        begin
            n = s[27:1] | {26'd0, s[0]};
            e = e + 9'd1;
        end
        else
        begin
            n = s[26:0];
        end
        // normalize left, stopping at the subnormal boundary
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!found && n[i])
            begin
                lz    = 5'(26 - i);
                found = 1'b1;
            end
        end
        lim = e - 9'd1;
        sh  = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
        n   = n << sh;
        e   = e - sh;
        if (e >= 9'd255)
        begin
            return {sgn, 8'hff, 23'd0};
        end
        field = n[26] ? e[7:0] : 8'd0;
        inc   = n[2] & (n[1] | n[0] | n[3]);
        body  = {1'b0, field, n[25:3]} + {31'd0, inc};
        return {sgn, body[30:0]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/fast_inverse_square_root.sv @@
// ---------------------------------------------------------------------------
// fast_inverse_square_root
// Fast inverse square root: takes one single-precision bit pattern per
// transfer and returns the seed-plus-one-Newton-step approximation of
// 1/sqrt(x), canonical quiet NaN for any NaN result. Five register stages
// (0.5*x, h*y0, p*y0, 1.5-t, y0*u), one float unit each; a new transfer is
// taken every cycle while the output is not stalled, and a stall at the
// output freezes only the full stages behind it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fast_inverse_square_root_macros.svh"

module fast_inverse_square_root
    import fisr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] operand_bits
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] result_bits
);

    mul_ops_t ops1;
    mul_ops_t ops2;
    mul_ops_t ops3;
    mul_ops_t ops5;
    pipe_t    d1;
    pipe_t    d2;
    pipe_t    d3;
    pipe_t    d4;
    pipe_t    d5;
    logic     v1;
    logic     v2;
    logic     v3;
    logic     v4;
    logic     r1;
    logic     r2;
    logic     r3;
    logic     r4;
    logic     out_is_nan;

    // halve input, form seed
    assign ops1.a    = s_axis_tdata;
    assign ops1.b    = HALF;
    assign ops1.seed = SEED_MAGIC - {1'b0, s_axis_tdata[31:1]};

    fisr_mul_stage u_half
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (ops1),
        .out_valid (v1),
        .out_ready (r1),
        .out_data  (d1)
    );

    // p = h * y0
    assign ops2.a    = d1.val;
    assign ops2.b    = d1.seed;
    assign ops2.seed = d1.seed;

    fisr_mul_stage u_hy
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (ops2),
        .out_valid (v2),
        .out_ready (r2),
        .out_data  (d2)
    );

    // t = p * y0
    assign ops3.a    = d2.val;
    assign ops3.b    = d2.seed;
    assign ops3.seed = d2.seed;

    fisr_mul_stage u_hyy
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_data   (ops3),
        .out_valid (v3),
        .out_ready (r3),
        .out_data  (d3)
    );

    // u = 1.5 - t
    fisr_sub_stage u_sub
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3),
        .in_ready  (r3),
        .in_data   (d3),
        .out_valid (v4),
        .out_ready (r4),
        .out_data  (d4)
    );

    // y = y0 * u
    assign ops5.a    = d4.seed;
    assign ops5.b    = d4.val;
    assign ops5.seed = d4.seed;

    fisr_mul_stage u_newton
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4),
        .in_ready  (r4),
        .in_data   (ops5),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (d5)
    );

    assign m_axis_tdata = d5.val;

    // any nan pattern on the output
    assign out_is_nan = (m_axis_tdata[30:23] == 8'hff) && (m_axis_tdata[22:0] != 23'd0);

    // checks
    `FISR_ASSERT(a_ready_chain, m_axis_tready, s_axis_tready)
    `FISR_ASSERT(a_nan_canon, m_axis_tvalid && out_is_nan, m_axis_tdata == QNAN)
    `FISR_ASSERT_NEXT(a_mid_hold, v3 && !r3, v3 && $stable(d3))
    `FISR_ASSERT_NEXT(a_fill, s_axis_tvalid && s_axis_tready, v1)

endmodule

`default_nettype wire

@@ rtl/core/fisr_mul_stage.sv @@
// ---------------------------------------------------------------------------
// fisr_mul_stage
// one registered single-precision multiply with valid and backpressure
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fisr_mul_stage
    import fisr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire mul_ops_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output pipe_t         out_data
);

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    // stage takes a transfer when empty or draining
    assign in_ready = !valid_reg || out_ready;

    // product and seed
    always_comb
    begin
        data_next.val  = fmul(in_data.a, in_data.b);
        data_next.seed = in_data.seed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/fisr_sub_stage.sv @@
// ---------------------------------------------------------------------------
// fisr_sub_stage
// registered 1.5 - t in single precision with valid and backpressure
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fisr_sub_stage
    import fisr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire pipe_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output pipe_t      out_data
);

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    assign in_ready = !valid_reg || out_ready;

    // subtract by adding the negated operand
    always_comb
    begin
        data_next.val  = fadd(THREE_HALF, {~in_data.val[31], in_data.val[30:0]});
        data_next.seed = in_data.seed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire
